// ===== hw/rtl/sas_pkg.sv =====
`timescale 1ns / 1ps

package sas_pkg;

    typedef enum logic [2:0] {
        K_BEGIN   = 3'd0,
        K_CHAR    = 3'd1,
        K_END     = 3'd2,
        K_DONE    = 3'd3,
        K_TOOMANY = 3'd4,
        K_UNBAL   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic [7:0] idx;
        logic       last;
    } ev_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] MAX_ARGS_RESET = 8'd100;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam int MAX_EV = 4;

    function automatic ev_t make_ev(kind_t kind, logic [7:0] ch, logic [7:0] idx);
        ev_t e;
        e.kind = kind;
        e.ch   = ch;
        e.idx  = idx;
        e.last = 1'b0;
        return e;
    endfunction

    // bit 8 set when the byte has an escape translation
    function automatic logic [8:0] translate(logic [7:0] c);
        logic [8:0] t;
        case (c)
            8'h61:     t = {1'b1, 8'd7};
            8'h62:     t = {1'b1, 8'd8};
            8'h66:     t = {1'b1, 8'd12};
            8'h6e:     t = {1'b1, 8'd10};
            8'h72:     t = {1'b1, 8'd13};
            8'h74:     t = {1'b1, 8'd9};
            8'h76:     t = {1'b1, 8'd11};
            CH_BSLASH: t = {1'b1, c};
            CH_SQUOTE: t = {1'b1, c};
            CH_DQUOTE: t = {1'b1, c};
            default:   t = {1'b0, c};
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/sas_in_if.sv =====
`timescale 1ns / 1ps

interface sas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_value;
    logic       end_line;

    modport source (output valid, output char_value, output end_line, input ready);
    modport sink   (input valid, input char_value, input end_line, output ready);
endinterface

// ===== hw/rtl/sas_out_if.sv =====
`timescale 1ns / 1ps

interface sas_out_if;
    import sas_pkg::*;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] out_char;
    logic [7:0] arg_index;
    logic       last;

    modport source (output valid, output kind, output out_char, output arg_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_char, input arg_index,
                    input last, output ready);
endinterface

// ===== hw/rtl/shell_argument_splitter_top.sv =====
`timescale 1ns / 1ps

// shell argument splitter
// in_ch carries one command line byte per word (char_value), or an end of
// line marker (end_line = 1). out_ch carries events: argument begin, character,
// argument end, line done, and the errors too many arguments and unbalanced
// quotes; last marks the final event caused by one input word.
// cfg_we / cfg_wdata write max_args; write only while the block is idle.
// the first event of a byte is on out_ch in the cycle after it is taken.
// throughput: one input word per cycle while each word gives at most one event
// and out_ch does not stall; a word that gives k events (up to 4) holds in_ch
// until k - 1 have left, as the 4-entry event register drains one per cycle.
// reset clears the line state and empties the event register, max_args returns to 100.
// a stall on out_ch holds the current event; in_ch.ready drops until the
// event register is down to its last event and that event is taken.
module shell_argument_splitter_top (
    input  logic       clk,
    input  logic       rst_n,
    sas_in_if.sink     in_ch,
    sas_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import sas_pkg::*;

    logic [7:0] max_args_reg;
    quote_t     quote_reg, quote_next;
    logic       open_reg, open_next;
    logic [7:0] count_reg, count_next;
    logic       esc_reg, esc_next;
    logic       fail_reg, fail_next;

    ev_t        ev_reg  [MAX_EV];
    ev_t        ev_next [MAX_EV];
    logic [2:0] ocnt_reg;
    logic [2:0] n;

    logic [8:0] total;
    logic [8:0] tr;
    logic       plain_en;
    logic [7:0] c;
    quote_t     mode;

    logic in_fire, out_pop;

    assign out_pop   = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (ocnt_reg == 3'd0) || (ocnt_reg == 3'd1 && out_ch.ready);
    assign in_fire   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        quote_next = quote_reg;
        open_next  = open_reg;
        count_next = count_reg;
        esc_next   = esc_reg;
        fail_next  = fail_reg;
        n          = 3'd0;
        total      = 9'd0;
        plain_en   = 1'b0;
        c          = in_ch.char_value;
        tr         = translate(c);
        mode       = Q_NONE;
        for (int i = 0; i < MAX_EV; i++)
        begin
            ev_next[i] = '0;
        end

        if (fail_reg)
        begin
            if (in_ch.end_line)
            begin
                quote_next = Q_NONE;
                open_next  = 1'b0;
                count_next = '0;
                esc_next   = 1'b0;
                fail_next  = 1'b0;
            end
        end
        else if (in_ch.end_line)
        begin
            if (esc_reg)
            begin
                if (!open_next)
                begin
                    open_next = 1'b1;
                    ev_next[n[1:0]] = make_ev(K_BEGIN, 8'd0, count_next);
                    n = n + 3'd1;
                end
                ev_next[n[1:0]] = make_ev(K_CHAR, CH_BSLASH, count_next);
                n = n + 3'd1;
            end
            if (quote_reg != Q_NONE)
            begin
                ev_next[n[1:0]] = make_ev(K_UNBAL, 8'd0, count_next);
                n = n + 3'd1;
            end
            else
            begin
                total = {1'b0, count_next};
                if (open_next)
                begin
                    ev_next[n[1:0]] = make_ev(K_END, 8'd0, count_next);
                    n = n + 3'd1;
                    total = total + 9'd1;
                end
                if (total[8])
                begin
                    total = {1'b0, COUNT_MAX};
                end
                ev_next[n[1:0]] = make_ev(K_DONE, 8'd0, total[7:0]);
                n = n + 3'd1;
            end
            quote_next = Q_NONE;
            open_next  = 1'b0;
            count_next = '0;
            esc_next   = 1'b0;
            fail_next  = 1'b0;
        end
        else
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                if (!open_next)
                begin
                    open_next = 1'b1;
                    ev_next[n[1:0]] = make_ev(K_BEGIN, 8'd0, count_next);
                    n = n + 3'd1;
                end
                if (tr[8])
                begin
                    ev_next[n[1:0]] = make_ev(K_CHAR, tr[7:0], count_next);
                    n = n + 3'd1;
                end
                else
                begin
                    ev_next[n[1:0]] = make_ev(K_CHAR, CH_BSLASH, count_next);
                    n = n + 3'd1;
                    plain_en = 1'b1;
                end
            end
            else
            begin
                plain_en = 1'b1;
            end

            if (plain_en)
            begin
                if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
                begin
                    if (open_next)
                    begin
                        if (quote_next == Q_NONE)
                        begin
                            ev_next[n[1:0]] = make_ev(K_END, 8'd0, count_next);
                            n = n + 3'd1;
                            if (count_next != COUNT_MAX)
                            begin
                                count_next = count_next + 8'd1;
                            end
                            open_next = 1'b0;
                        end
                        else
                        begin
                            ev_next[n[1:0]] = make_ev(K_CHAR, c, count_next);
                            n = n + 3'd1;
                        end
                    end
                end
                else if (c inside {CH_SQUOTE, CH_DQUOTE})
                begin
                    mode = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                    if (!open_next)
                    begin
                        open_next = 1'b1;
                        ev_next[n[1:0]] = make_ev(K_BEGIN, 8'd0, count_next);
                        n = n + 3'd1;
                        quote_next = mode;
                    end
                    else if (quote_next == mode)
                    begin
                        quote_next = Q_NONE;
                    end
                    else if (quote_next == Q_NONE)
                    begin
                        quote_next = mode;
                    end
                    else
                    begin
                        ev_next[n[1:0]] = make_ev(K_CHAR, c, count_next);
                        n = n + 3'd1;
                    end
                end
                else if (c == CH_BSLASH && quote_next != Q_SINGLE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    if (!open_next)
                    begin
                        open_next = 1'b1;
                        ev_next[n[1:0]] = make_ev(K_BEGIN, 8'd0, count_next);
                        n = n + 3'd1;
                    end
                    ev_next[n[1:0]] = make_ev(K_CHAR, c, count_next);
                    n = n + 3'd1;
                end
            end

            if (count_next >= max_args_reg)
            begin
                ev_next[n[1:0]] = make_ev(K_TOOMANY, 8'd0, count_next);
                n = n + 3'd1;
                fail_next = 1'b1;
            end
        end

        if (n != 3'd0)
        begin
            ev_next[2'(n - 3'd1)].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= MAX_ARGS_RESET;
        end
        else if (cfg_we)
        begin
            max_args_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= Q_NONE;
            open_reg  <= 1'b0;
            count_reg <= '0;
            esc_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            ocnt_reg  <= '0;
        end
        else if (in_fire)
        begin
            quote_reg <= quote_next;
            open_reg  <= open_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
            fail_reg  <= fail_next;
            ocnt_reg  <= n;
        end
        else if (out_pop)
        begin
            ocnt_reg <= ocnt_reg - 3'd1;
        end
    end

    // event register shifts toward slot 0 as events leave
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_EV; i++)
            begin
                ev_reg[i] <= ev_next[i];
            end
        end
        else if (out_pop)
        begin
            for (int i = 0; i < MAX_EV - 1; i++)
            begin
                ev_reg[i] <= ev_reg[i + 1];
            end
        end
    end

    assign out_ch.valid     = (ocnt_reg != 3'd0);
    assign out_ch.kind      = ev_reg[0].kind;
    assign out_ch.out_char  = ev_reg[0].ch;
    assign out_ch.arg_index = ev_reg[0].idx;
    assign out_ch.last      = ev_reg[0].last;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 3'd4)
        else $error("event count out of range");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (ocnt_reg == 3'd1) |-> ev_reg[0].last)
        else $error("final event of a word lacks last");

    a_not_last_early: assert property (@(posedge clk) disable iff (!rst_n)
        (ocnt_reg > 3'd1) |-> !ev_reg[0].last)
        else $error("last set before final event");

    a_events_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && n != 3'd0) |=> (out_ch.valid && ocnt_reg == $past(n)))
        else $error("events of accepted word not loaded");

    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && fail_reg) |=> !out_ch.valid)
        else $error("failed line produced an event");

endmodule
